// ----- sv/tssd_pkg.sv -----
// shared types, constants and the crc-8 step for the thermometer scratchpad decoder
// no dependencies; used by temp_sensor_scratchpad_decode
`timescale 1ns / 1ps

package tssd_pkg;

   localparam int unsigned FrameLen     = 9;
   localparam int unsigned StoreDepth   = 8;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [7:0]  CrcPoly      = 8'h8C;
   localparam logic [7:0]  CountRemMark = 8'h10;
   localparam logic [7:0]  ResMask      = 8'h60;
   localparam logic [7:0]  Res9Bit      = 8'h00;
   localparam logic [7:0]  Res10Bit     = 8'h20;
   localparam logic [7:0]  Res11Bit     = 8'h40;
   localparam logic [15:0] CountRemKeep = 16'hFFF0;
   localparam logic [15:0] CountRemBias = 16'd12;
   localparam logic [15:0] Mask9Bit     = 16'hFFF8;
   localparam logic [15:0] Mask10Bit    = 16'hFFFC;
   localparam logic [15:0] Mask11Bit    = 16'hFFFE;
   localparam logic signed [22:0] CentiScale = 23'sd100;

   // byte positions inside the scratchpad
   localparam logic [2:0] ByteTempLo = 3'd0;
   localparam logic [2:0] ByteTempHi = 3'd1;
   localparam logic [2:0] ByteConfig = 3'd4;
   localparam logic [2:0] ByteCntRem = 3'd6;
   localparam logic [2:0] ByteCntPer = 3'd7;
   localparam logic [CountWidth-1:0] LastByte = CountWidth'(FrameLen - 1);

   // register map, word index
   localparam logic [0:0] RegOldFamily = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ALL_ZERO = 2'd1,
      STATUS_CRC_BAD  = 2'd2
   } status_type;

   typedef logic [CountWidth-1:0] count_type;

   // one byte through the reflected crc-8, lsb first
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      c = crc;
      d = data;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ d[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

// ----- sv/temp_sensor_scratchpad_decode.sv -----
// scratchpad decoder for a 1-wire thermometer: crc check, raw and centidegree conversion
// depends on tssd_pkg
`timescale 1ns / 1ps
//
// usage
//   req channel: one scratchpad byte per request, byte 0 first; req_tuser[0] marks
//   byte 0 and restarts the frame. after nine bytes the count wraps on its own.
//   rsp channel: one result per nine-byte frame with the status in rsp_tuser and
//   raw 1/16 degree plus hundredths of a degree in rsp_tdata. failed reads give zeros.
//   csr port: word 0 bit 0 selects the old 9-bit family with count-remain refinement.
// timing
//   one request per cycle while the result path keeps up. the first stage is loaded at
//   the edge that takes the ninth byte (crc check and raw value), the result register
//   from it once that register is free (multiply by 100, rounding toward zero and
//   saturation); rsp_tvalid comes straight from the result register.
// reset
//   synchronous reset empties both stages, clears the byte count, crc and the mode bit.
// backpressure
//   while rsp_tready is low the result holds; requests are still taken until a second
//   finished frame waits behind it, then req_tready drops until the result leaves.
//

module temp_sensor_scratchpad_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scratch_byte
   input  logic [0:0]  req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] raw_temperature, [31:16] centi_degrees
   output logic [1:0]  rsp_tuser,   // [1:0] read_status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [tssd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [tssd_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [tssd_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic        csr_pready
);

   // control and accumulators
   logic                  mode_ff, mode_in;
   tssd_pkg::count_type   count_ff, count_in;
   logic [7:0]            crc_ff, crc_in;
   logic [7:0]            or_ff, or_in;
   logic [7:0]            scratch_ff [tssd_pkg::StoreDepth];

   // stage a: status and raw
   logic                  a_valid_ff, a_valid_in;
   tssd_pkg::status_type  a_status_ff, a_status_in;
   logic [15:0]           a_raw_ff, a_raw_in;

   // stage b: result register
   logic                  b_valid_ff, b_valid_in;
   tssd_pkg::status_type  b_status_ff;
   logic [15:0]           b_raw_ff;
   logic [15:0]           b_centi_ff, b_centi_in;

   logic                  b_ready, a_move, req_fire, frame_done, csr_write;
   tssd_pkg::count_type   count_eff;
   logic [7:0]            crc_base, or_base, or_all;
   logic [15:0]           word, raw_old, raw_new, conv_raw;
   logic signed [22:0]    prod, biased;
   logic signed [18:0]    quot;

   assign b_ready    = !b_valid_ff || rsp_tready;
   assign a_move     = a_valid_ff && b_ready;
   assign req_tready = !a_valid_ff || b_ready;
   assign req_fire   = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == tssd_pkg::RegOldFamily)
                       ? {{(tssd_pkg::CsrDataWidth-1){1'b0}}, mode_ff}
                       : '0;

   // byte position of this request, frame restart on the start mark
   assign count_eff  = (req_tuser[0] || count_ff > tssd_pkg::LastByte) ? '0 : count_ff;
   assign crc_base   = (count_eff == '0) ? 8'h00 : crc_ff;
   assign or_base    = (count_eff == '0) ? 8'h00 : or_ff;
   assign or_all     = or_base | req_tdata;
   assign frame_done = req_fire && (count_eff == tssd_pkg::LastByte);

   // raw conversion by family
   assign word = {scratch_ff[tssd_pkg::ByteTempHi], scratch_ff[tssd_pkg::ByteTempLo]};

   always_comb begin
      raw_old = {word[12:0], 3'b000};
      if (scratch_ff[tssd_pkg::ByteCntPer] == tssd_pkg::CountRemMark) begin
         raw_old = (raw_old & tssd_pkg::CountRemKeep) + tssd_pkg::CountRemBias
                   - {8'h00, scratch_ff[tssd_pkg::ByteCntRem]};
      end
      case (scratch_ff[tssd_pkg::ByteConfig] & tssd_pkg::ResMask)
         tssd_pkg::Res9Bit:  raw_new = word & tssd_pkg::Mask9Bit;
         tssd_pkg::Res10Bit: raw_new = word & tssd_pkg::Mask10Bit;
         tssd_pkg::Res11Bit: raw_new = word & tssd_pkg::Mask11Bit;
         default:            raw_new = word;
      endcase
      conv_raw = mode_ff ? raw_old : raw_new;
   end

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && csr_paddr[2] == tssd_pkg::RegOldFamily) begin
         mode_in = csr_pwdata[0];
      end

      count_in = count_ff;
      crc_in   = crc_ff;
      or_in    = or_ff;
      if (req_fire) begin
         or_in = or_all;
         if (frame_done) begin
            count_in = '0;
         end else begin
            count_in = count_eff + 1'b1;
            crc_in   = tssd_pkg::crc_update(crc_base, req_tdata);
         end
      end

      a_status_in = tssd_pkg::STATUS_OK;
      a_raw_in    = '0;
      if (or_all == 8'h00) begin
         a_status_in = tssd_pkg::STATUS_ALL_ZERO;
      end else if (crc_base != req_tdata) begin
         a_status_in = tssd_pkg::STATUS_CRC_BAD;
      end else begin
         a_raw_in = conv_raw;
      end

      if (frame_done) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end

      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (rsp_tready) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   // raw * 100 / 16, toward zero, then clamp to 16 bits
   always_comb begin
      prod   = $signed({{7{a_raw_ff[15]}}, a_raw_ff}) * tssd_pkg::CentiScale;
      biased = prod + (prod[22] ? 23'sd15 : 23'sd0);
      quot   = biased[22:4];
      if (quot[18:15] == 4'b0000 || quot[18:15] == 4'b1111) begin
         b_centi_in = quot[15:0];
      end else if (quot[18]) begin
         b_centi_in = 16'h8000;
      end else begin
         b_centi_in = 16'h7FFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         count_ff   <= '0;
         crc_ff     <= '0;
         or_ff      <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         or_ff      <= or_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !frame_done) begin
         scratch_ff[count_eff[2:0]] <= req_tdata;
      end
      if (frame_done) begin
         a_status_ff <= a_status_in;
         a_raw_ff    <= a_raw_in;
      end
      if (a_move) begin
         b_status_ff <= a_status_ff;
         b_raw_ff    <= a_raw_ff;
         b_centi_ff  <= b_centi_in;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {b_centi_ff, b_raw_ff};
   assign rsp_tuser  = b_status_ff;

endmodule

// ----- tb/temp_sensor_scratchpad_decode_tb.sv -----
// self-checking testbench for temp_sensor_scratchpad_decode: directed frames, then random
// frames and noise under several idle and stall mixes, checked against an in-bench decoder
// depends on tssd_pkg and temp_sensor_scratchpad_decode
`timescale 1ns / 1ps

module temp_sensor_scratchpad_decode_tb;

   localparam int IdleLimit  = 1000;
   localparam int MaxGap     = 24;
   localparam int PhaseItems = 218;
   localparam int DrainWait  = 6;

   localparam logic [tssd_pkg::CsrAddrWidth-1:0] OldFamilyAddr =
      {tssd_pkg::RegOldFamily, 2'b00};
   localparam logic [tssd_pkg::CsrAddrWidth-1:0] SpareAddr = 3'd4;

   typedef struct {
      tssd_pkg::status_type status;
      logic [15:0]          raw;
      logic [15:0]          centi;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] scratch_byte
   logic [0:0]  req_tuser;   // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // [15:0] raw_temperature, [31:16] centi_degrees
   logic [1:0]  rsp_tuser;   // [1:0] read_status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [tssd_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [tssd_pkg::CsrDataWidth-1:0] csr_pwdata;
   logic [tssd_pkg::CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   // decoder state mirrored in the bench
   logic       mode_bit;
   int         byte_idx;
   logic [7:0] crc_run;
   logic [7:0] or_run;
   logic [7:0] scratch [tssd_pkg::StoreDepth];

   reading_type expected_readings [$];
   logic [7:0]  frame_buf [tssd_pkg::FrameLen];
   int          failures;
   int          items_sent;
   int          quiet_cycles;
   int          send_idle_pct;
   int          stall_pct;
   int          stall_run;

   temp_sensor_scratchpad_decode dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // maxim crc-8, data bits taken lsb first
   function automatic logic [7:0] crc8_step(input logic [7:0] c_in, input logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = c_in;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[k];
         c  = {1'b0, c[7:1]} ^ ({8{fb}} & tssd_pkg::CrcPoly);
      end
      return c;
   endfunction

   function automatic logic [15:0] scale_centi(input logic [15:0] raw);
      int s;
      int q;
      s = int'($signed(raw));
      q = (s * 100) / 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic start);
      reading_type r;
      logic [15:0] t;
      if (start || byte_idx >= tssd_pkg::FrameLen) byte_idx = 0;
      if (byte_idx == 0) begin
         crc_run = 8'h00;
         or_run  = 8'h00;
      end
      or_run = or_run | b;
      if (byte_idx < tssd_pkg::StoreDepth) begin
         scratch[byte_idx] = b;
         crc_run = crc8_step(crc_run, b);
         byte_idx++;
      end else begin
         byte_idx = 0;
         r.raw    = 16'h0000;
         r.centi  = 16'h0000;
         if (or_run == 8'h00) begin
            r.status = tssd_pkg::STATUS_ALL_ZERO;
         end else if (crc_run != b) begin
            r.status = tssd_pkg::STATUS_CRC_BAD;
         end else begin
            r.status = tssd_pkg::STATUS_OK;
            t = {scratch[tssd_pkg::ByteTempHi], scratch[tssd_pkg::ByteTempLo]};
            if (mode_bit) begin
               t = t << 3;
               // count-remain refinement only when count-per-degree reads 16
               if (scratch[tssd_pkg::ByteCntPer] == tssd_pkg::CountRemMark)
                  t = (t & tssd_pkg::CountRemKeep) + tssd_pkg::CountRemBias
                      - {8'h00, scratch[tssd_pkg::ByteCntRem]};
            end else begin
               case (scratch[tssd_pkg::ByteConfig] & tssd_pkg::ResMask)
                  tssd_pkg::Res9Bit:  t = t & tssd_pkg::Mask9Bit;
                  tssd_pkg::Res10Bit: t = t & tssd_pkg::Mask10Bit;
                  tssd_pkg::Res11Bit: t = t & tssd_pkg::Mask11Bit;
                  default:  ;
               endcase
            end
            r.raw   = t;
            r.centi = scale_centi(t);
         end
         expected_readings.push_back(r);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: status %0d raw %h centi %h",
                        rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[15:0] !== want.raw ||
                rsp_tdata[31:16] !== want.centi) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch: expected status %0d raw %h centi %h, got %0d %h %h",
                           want.status, want.raw, want.centi,
                           rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
            end
         end
      end
   end

   // receiver backpressure, stall runs are capped
   always @(negedge clock) begin
      if (stall_pct != 0 && stall_run < MaxGap && $urandom_range(99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_run  <= stall_run + 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_run  <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("temp_sensor_scratchpad_decode test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = 0;
      while (gap < MaxGap && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, start);
      items_sent++;
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      req_idle();
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tssd_pkg::CsrAddrWidth-1:0] addr,
                            input logic value);
      logic [tssd_pkg::CsrDataWidth-1:0] word;
      word    = $urandom;
      word[0] = value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[tssd_pkg::CsrAddrWidth-1:2] == tssd_pkg::RegOldFamily) mode_bit = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // builds a scratchpad image with a matching crc in frame_buf
   task automatic fill_frame(input logic [15:0] temp, input logic [7:0] cfg,
                             input logic [7:0] rem, input logic [7:0] per);
      logic [7:0] crc;
      frame_buf[tssd_pkg::ByteTempLo] = temp[7:0];
      frame_buf[tssd_pkg::ByteTempHi] = temp[15:8];
      frame_buf[2]                    = 8'($urandom);
      frame_buf[3]                    = 8'($urandom);
      frame_buf[tssd_pkg::ByteConfig] = cfg;
      frame_buf[5]                    = 8'($urandom);
      frame_buf[tssd_pkg::ByteCntRem] = rem;
      frame_buf[tssd_pkg::ByteCntPer] = per;
      crc = 8'h00;
      for (int i = 0; i < tssd_pkg::StoreDepth; i++) crc = crc8_step(crc, frame_buf[i]);
      frame_buf[tssd_pkg::FrameLen-1] = crc;
   endtask

   task automatic send_frame(input logic start_first);
      for (int i = 0; i < tssd_pkg::FrameLen; i++)
         send_byte(frame_buf[i], (i == 0) ? start_first : 1'b0);
   endtask

   task automatic test_all_zero_frame();
      for (int i = 0; i < tssd_pkg::FrameLen; i++) send_byte(8'h00, i == 0);
   endtask

   task automatic test_restart_mid_frame();
      // two bytes of a frame begun without a start mark, then a restart
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
      fill_frame(16'h7FFF, 8'h7F, 8'hFF, 8'hFF);
      send_frame(1'b1);
   endtask

   task automatic test_register_map();
      wait_for_drain();
      // write to an unmapped word must leave the mode alone
      csr_write(SpareAddr, 1'b1);
      fill_frame(16'h8000, 8'h60, 8'h00, tssd_pkg::CountRemMark);
      send_frame(1'b0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input logic mode);
      int         first;
      int         frames;
      int         kind;
      int         n;
      logic [15:0] temp;
      logic       start;
      wait_for_drain();
      csr_write(OldFamilyAddr, mode);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first         = items_sent;
      frames        = 0;
      while (items_sent - first < PhaseItems) begin
         kind = $urandom_range(99);
         if (kind < 4) begin
            test_all_zero_frame();
         end else if (kind < 80) begin
            temp = 16'($urandom);
            case ($urandom_range(7))
               0: temp[15:8] = 8'h7F;
               1: temp[15:8] = 8'h80;
               2: temp[15:8] = 8'hFF;
               3: temp[15:8] = 8'h00;
               4, 5: begin
                  temp = 16'($urandom_range(0, 16'h1400));
                  if ($urandom_range(1)) temp = -temp;
               end
               default: ;
            endcase
            fill_frame(temp, 8'($urandom), 8'($urandom),
                       $urandom_range(1) ? tssd_pkg::CountRemMark : 8'($urandom));
            if ($urandom_range(99) < 15)
               frame_buf[tssd_pkg::FrameLen-1] =
                  frame_buf[tssd_pkg::FrameLen-1] ^ 8'($urandom_range(1, 255));
            // off the frame grid a start mark is needed to realign
            start = (byte_idx == 0) ? ($urandom_range(99) < 60) : 1'b1;
            send_frame(start);
         end else begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom), $urandom_range(99) < 15);
         end
         frames++;
         // hold back requests until every result is out
         if (frames % 20 == 19) wait_for_drain();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mode_bit    = 1'b0;
      byte_idx    = 0;
      crc_run     = 8'h00;
      or_run      = 8'h00;
      for (int i = 0; i < tssd_pkg::StoreDepth; i++) scratch[i] = 8'h00;
      failures      = 0;
      items_sent    = 0;
      quiet_cycles  = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      stall_run     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_all_zero_frame();
      test_restart_mid_frame();
      test_register_map();
      run_phase(0, 0, 1'b0);
      run_phase(66, 0, 1'b1);
      run_phase(0, 66, 1'b0);
      run_phase(36, 36, 1'b1);
      wait_for_drain();
      repeat (10) @(posedge clock);

      if (failures == 0 && expected_readings.size() == 0) begin
         $display("temp_sensor_scratchpad_decode test passed");
      end else begin
         $display("temp_sensor_scratchpad_decode test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/tssd_pkg.sv
sv/temp_sensor_scratchpad_decode.sv
tb/temp_sensor_scratchpad_decode_tb.sv
